// ===== design/psse_pkg.sv =====
// shared types and constants for the pressure sensor spi slave emulator
`timescale 1ns / 1ps

package psse_pkg;

  localparam int NUM_COEFF = 6;
  localparam int COEFF_W   = 16;
  localparam int CFG_IDX_W = 3;

  typedef logic [COEFF_W-1:0]   coeff_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [3:0]           phase_t;
  typedef logic [2:0]           word_idx_t;
  typedef logic [1:0]           pend_t;

  // one input beat
  typedef struct packed {
    logic        op;
    logic [7:0]  spi_in;
    logic [23:0] conv_value;
  } item_t;

  // one result beat
  typedef struct packed {
    logic [7:0] spi_out;
    pend_t      conv_pending;
  } result_t;

  localparam coeff_t COEFF_RESET [NUM_COEFF] = '{
    16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312
  };

  // prom words that are not configurable
  localparam word_idx_t PROM_IDX_FIRST = 3'd0;
  localparam word_idx_t PROM_IDX_LAST  = 3'd7;
  localparam coeff_t    PROM_WORD_FIRST = 16'hABCD;
  localparam coeff_t    PROM_WORD_LAST  = 16'h1234;

  // input op codes
  localparam logic OP_SPI_BYTE  = 1'b0;
  localparam logic OP_CONV_DATA = 1'b1;

  // command decode
  localparam logic [3:0] CMD_PROM_NIB = 4'hA;
  localparam logic [3:0] CMD_D1_NIB   = 4'h4;
  localparam logic [3:0] CMD_D2_NIB   = 4'h5;
  localparam logic [7:0] CMD_RESET    = 8'h1E;
  localparam logic [7:0] CMD_ADC_READ = 8'h00;

  localparam logic [7:0] ADC_MARKER = 8'hFE;

  // phase codes
  localparam phase_t PH_IDLE      = 4'd0;
  localparam phase_t PH_PROM_MSB  = 4'd1;
  localparam phase_t PH_PROM_LSB  = 4'd2;
  localparam phase_t PH_RESETTING = 4'd3;
  localparam phase_t PH_ADC_MARK  = 4'd4;
  localparam phase_t PH_ADC_B0    = 4'd5;
  localparam phase_t PH_ADC_B1    = 4'd6;
  localparam phase_t PH_ADC_B2    = 4'd7;
  localparam phase_t PH_CONV_D1   = 4'd8;
  localparam phase_t PH_CONV_D2   = 4'd9;

  // pending conversion codes
  localparam pend_t PEND_NONE = 2'd0;
  localparam pend_t PEND_D1   = 2'd1;
  localparam pend_t PEND_D2   = 2'd2;

endpackage

// ===== design/psse_coeff_regs.sv =====
// calibration word registers and prom word lookup
`timescale 1ns / 1ps

module psse_coeff_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  psse_pkg::cfg_idx_t  cfg_idx,
  input  psse_pkg::coeff_t    cfg_wdata,
  input  psse_pkg::word_idx_t word_idx,
  output psse_pkg::coeff_t    prom_word
);

  psse_pkg::coeff_t coeff_r   [psse_pkg::NUM_COEFF];
  psse_pkg::coeff_t coeff_nxt [psse_pkg::NUM_COEFF];

  // writes beyond the register list fall through untouched
  always_comb begin
    for (int i = 0; i < psse_pkg::NUM_COEFF; i++) begin
      coeff_nxt[i] = coeff_r[i];
      if (cfg_we && (cfg_idx == psse_pkg::CFG_IDX_W'(i))) begin
        coeff_nxt[i] = cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < psse_pkg::NUM_COEFF; i++) begin
      if (!rst_n) begin
        coeff_r[i] <= psse_pkg::COEFF_RESET[i];
      end else begin
        coeff_r[i] <= coeff_nxt[i];
      end
    end
  end

  always_comb begin
    if (word_idx == psse_pkg::PROM_IDX_FIRST) begin
      prom_word = psse_pkg::PROM_WORD_FIRST;
    end else if (word_idx == psse_pkg::PROM_IDX_LAST) begin
      prom_word = psse_pkg::PROM_WORD_LAST;
    end else begin
      prom_word = coeff_r[3'(word_idx - 3'd1)];
    end
  end

endmodule

// ===== design/psse_cmd_fsm.sv =====
// command state machine, conversion store and response byte select
`timescale 1ns / 1ps

module psse_cmd_fsm (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  psse_pkg::item_t      item,
  input  psse_pkg::coeff_t     prom_word,
  output psse_pkg::word_idx_t  word_idx_nxt,
  output psse_pkg::result_t    result
);

  psse_pkg::phase_t    phase_r, phase_nxt;
  psse_pkg::word_idx_t word_idx_r;
  logic [23:0]         conv_bytes_r, conv_bytes_nxt;

  always_comb begin
    phase_nxt      = phase_r;
    word_idx_nxt   = word_idx_r;
    conv_bytes_nxt = conv_bytes_r;
    if (item.op == psse_pkg::OP_CONV_DATA) begin
      // data with no conversion pending is dropped
      if (phase_r == psse_pkg::PH_CONV_D1 || phase_r == psse_pkg::PH_CONV_D2) begin
        conv_bytes_nxt = item.conv_value;
        phase_nxt      = psse_pkg::PH_IDLE;
      end
    end else begin
      unique case (phase_r)
        psse_pkg::PH_IDLE: begin
          priority if (item.spi_in[7:4] == psse_pkg::CMD_PROM_NIB) begin
            word_idx_nxt = item.spi_in[3:1];
            phase_nxt    = psse_pkg::PH_PROM_MSB;
          end else if (item.spi_in[7:4] == psse_pkg::CMD_D1_NIB) begin
            phase_nxt = psse_pkg::PH_CONV_D1;
          end else if (item.spi_in[7:4] == psse_pkg::CMD_D2_NIB) begin
            phase_nxt = psse_pkg::PH_CONV_D2;
          end else if (item.spi_in == psse_pkg::CMD_RESET) begin
            phase_nxt = psse_pkg::PH_RESETTING;
          end else if (item.spi_in == psse_pkg::CMD_ADC_READ) begin
            phase_nxt = psse_pkg::PH_ADC_MARK;
          end else begin
            phase_nxt = psse_pkg::PH_IDLE;
          end
        end
        psse_pkg::PH_PROM_MSB:  phase_nxt = psse_pkg::PH_PROM_LSB;
        psse_pkg::PH_PROM_LSB:  phase_nxt = psse_pkg::PH_IDLE;
        psse_pkg::PH_RESETTING: phase_nxt = psse_pkg::PH_IDLE;
        psse_pkg::PH_ADC_MARK:  phase_nxt = psse_pkg::PH_ADC_B0;
        psse_pkg::PH_ADC_B0:    phase_nxt = psse_pkg::PH_ADC_B1;
        psse_pkg::PH_ADC_B1:    phase_nxt = psse_pkg::PH_ADC_B2;
        psse_pkg::PH_ADC_B2:    phase_nxt = psse_pkg::PH_IDLE;
        // pending conversion swallows spi bytes
        default:                phase_nxt = phase_r;
      endcase
    end
  end

  // response follows the phase the beat leaves behind
  always_comb begin
    unique case (phase_nxt)
      psse_pkg::PH_PROM_MSB: result.spi_out = prom_word[15:8];
      psse_pkg::PH_PROM_LSB: result.spi_out = prom_word[7:0];
      psse_pkg::PH_ADC_MARK: result.spi_out = psse_pkg::ADC_MARKER;
      psse_pkg::PH_ADC_B0:   result.spi_out = conv_bytes_nxt[23:16];
      psse_pkg::PH_ADC_B1:   result.spi_out = conv_bytes_nxt[15:8];
      psse_pkg::PH_ADC_B2:   result.spi_out = conv_bytes_nxt[7:0];
      default:               result.spi_out = 8'd0;
    endcase
    if (phase_nxt == psse_pkg::PH_CONV_D1) begin
      result.conv_pending = psse_pkg::PEND_D1;
    end else if (phase_nxt == psse_pkg::PH_CONV_D2) begin
      result.conv_pending = psse_pkg::PEND_D2;
    end else begin
      result.conv_pending = psse_pkg::PEND_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= psse_pkg::PH_IDLE;
      word_idx_r   <= '0;
      conv_bytes_r <= '0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      word_idx_r   <= word_idx_nxt;
      conv_bytes_r <= conv_bytes_nxt;
    end
  end

endmodule

// ===== design/pressure_sensor_spi_slave_emulator.sv =====
// top level: input register, command logic and result register
`timescale 1ns / 1ps

// Emulates the slave side of a barometric sensor's spi command protocol. Each
// input beat is either a received spi byte or a conversion result; each beat
// yields exactly one result beat carrying the byte to load for the next spi
// transfer and the pending conversion code. An accepted beat sits in an input
// register, passes the command decode and response mux, and lands in the
// result register once the result side is free, so one beat per cycle is
// sustained as long as the result side does not stall. The user must write the
// six calibration words through the cfg port only while no beat is in flight;
// the block does not enforce this. Prom indices 0 and 7 return fixed words.
module pressure_sensor_spi_slave_emulator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [7:0]  in_spi_in,
  input  logic [23:0] in_conv_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_spi_out,
  output logic [1:0]  out_conv_pending,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [15:0] cfg_wdata
);

  logic                in_valid_r, in_valid_nxt;
  psse_pkg::item_t     in_item_r;
  logic                out_valid_r, out_valid_nxt;
  psse_pkg::result_t   out_res_r;
  psse_pkg::result_t   fsm_res;
  psse_pkg::word_idx_t word_idx_nxt;
  psse_pkg::coeff_t    prom_word;
  logic                out_free;
  logic                step;
  logic                in_take;

  assign out_free = !out_valid_r || !out_stall;
  assign step     = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  assign in_valid_nxt  = in_take || (in_valid_r && !step);
  assign out_valid_nxt = step || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r.op         <= in_op;
      in_item_r.spi_in     <= in_spi_in;
      in_item_r.conv_value <= in_conv_value;
    end
    if (step) begin
      out_res_r <= fsm_res;
    end
  end

  psse_coeff_regs u_coeff (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .word_idx  (word_idx_nxt),
    .prom_word (prom_word)
  );

  psse_cmd_fsm u_fsm (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .item         (in_item_r),
    .prom_word    (prom_word),
    .word_idx_nxt (word_idx_nxt),
    .result       (fsm_res)
  );

  assign out_valid        = out_valid_r;
  assign out_spi_out      = out_res_r.spi_out;
  assign out_conv_pending = out_res_r.conv_pending;

  // a pending conversion always answers zero
  a_pending_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.conv_pending != psse_pkg::PEND_NONE) |->
      out_res_r.spi_out == 8'd0)
    else $error("nonzero spi byte while conversion pending");

  a_pending_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_res_r.conv_pending != 2'd3)
    else $error("illegal pending code");

  // every beat that leaves the input register shows up as a result
  a_step_result: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("processed beat produced no result");

  // a held input beat is not dropped
  a_in_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !step |=> in_valid_r)
    else $error("input beat lost");

endmodule

// ===== test/tb_pressure_sensor_spi_slave_emulator.sv =====
// testbench for the pressure sensor spi slave emulator: predicted replies vs dut
`timescale 1ns / 1ps

module tb_pressure_sensor_spi_slave_emulator;
  import psse_pkg::*;

  localparam int RANDOM_ROUNDS = 6;
  localparam int BEATS_PER_ROUND = 75;
  localparam int GAP_PERCENT = 22;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_op = OP_SPI_BYTE;
  logic [7:0]  in_spi_in = '0;
  logic [23:0] in_conv_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_spi_out;
  logic [1:0]  out_conv_pending;
  logic        cfg_we = 1'b0;
  cfg_idx_t    cfg_idx = '0;
  coeff_t      cfg_wdata = '0;

  pressure_sensor_spi_slave_emulator dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_op(in_op),
    .in_spi_in(in_spi_in),
    .in_conv_value(in_conv_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_spi_out(out_spi_out),
    .out_conv_pending(out_conv_pending),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // beats waiting for the driver, and replies the slave owes
  item_t   host_beats[$];
  result_t replies_due[$];
  int      beats_queued = 0;
  int      mismatch_count = 0;
  bit      no_gaps = 1'b0;

  // emulated slave state
  coeff_t    slave_coeff[NUM_COEFF];
  phase_t    slave_phase;
  word_idx_t slave_word;
  logic [23:0] slave_conv;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch @%0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic emulate_slave(input item_t beat);
    result_t reply;
    coeff_t  word;
    if (beat.op == OP_CONV_DATA) begin
      if (slave_phase == PH_CONV_D1 || slave_phase == PH_CONV_D2) begin
        slave_conv = beat.conv_value;
        slave_phase = PH_IDLE;
      end
    end else begin
      case (slave_phase)
        PH_IDLE: begin
          case (beat.spi_in[7:4])
            CMD_PROM_NIB: begin
              slave_word = beat.spi_in[3:1];
              slave_phase = PH_PROM_MSB;
            end
            CMD_D1_NIB: slave_phase = PH_CONV_D1;
            CMD_D2_NIB: slave_phase = PH_CONV_D2;
            default: begin
              if (beat.spi_in == CMD_RESET) slave_phase = PH_RESETTING;
              else if (beat.spi_in == CMD_ADC_READ) slave_phase = PH_ADC_MARK;
            end
          endcase
        end
        PH_PROM_MSB: slave_phase = PH_PROM_LSB;
        PH_ADC_MARK: slave_phase = PH_ADC_B0;
        PH_ADC_B0:   slave_phase = PH_ADC_B1;
        PH_ADC_B1:   slave_phase = PH_ADC_B2;
        // trailing byte of a multi-byte answer or of a reset just returns to idle
        PH_PROM_LSB, PH_RESETTING, PH_ADC_B2: slave_phase = PH_IDLE;
        default: ;
      endcase
    end

    if (slave_word == PROM_IDX_FIRST) word = PROM_WORD_FIRST;
    else if (slave_word == PROM_IDX_LAST) word = PROM_WORD_LAST;
    else word = slave_coeff[3'(slave_word - 3'd1)];

    case (slave_phase)
      PH_PROM_MSB: reply.spi_out = word[15:8];
      PH_PROM_LSB: reply.spi_out = word[7:0];
      PH_ADC_MARK: reply.spi_out = ADC_MARKER;
      PH_ADC_B0:   reply.spi_out = slave_conv[23:16];
      PH_ADC_B1:   reply.spi_out = slave_conv[15:8];
      PH_ADC_B2:   reply.spi_out = slave_conv[7:0];
      default:     reply.spi_out = 8'h00;
    endcase
    if (slave_phase == PH_CONV_D1) reply.conv_pending = PEND_D1;
    else if (slave_phase == PH_CONV_D2) reply.conv_pending = PEND_D2;
    else reply.conv_pending = PEND_NONE;
    replies_due.push_back(reply);
  endtask

  // driver: payload holds while stalled, gaps only between beats
  always @(posedge clk) begin
    item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) emulate_slave(item_t'({in_op, in_spi_in, in_conv_value}));
      if (!in_valid || !in_stall) begin
        if (host_beats.size() != 0 && (no_gaps || $urandom_range(0, 99) >= GAP_PERCENT)) begin
          nxt = host_beats.pop_front();
          in_valid <= 1'b1;
          in_op <= nxt.op;
          in_spi_in <= nxt.spi_in;
          in_conv_value <= nxt.conv_value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each reply beat against the oldest one due
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          report_mismatch("reply with none due", int'(out_spi_out), 0);
        end else begin
          want = replies_due.pop_front();
          if (out_spi_out !== want.spi_out)
            report_mismatch("spi_out", int'(out_spi_out), int'(want.spi_out));
          if (out_conv_pending !== want.conv_pending)
            report_mismatch("conv_pending", int'(out_conv_pending),
                            int'(want.conv_pending));
        end
      end
      out_stall <= !no_gaps && ($urandom_range(0, 99) < GAP_PERCENT);
    end
  end

  task automatic queue_spi(input logic [7:0] b);
    item_t it;
    it.op = OP_SPI_BYTE;
    it.spi_in = b;
    it.conv_value = 24'($urandom_range(0, 24'hFFFFFF));
    host_beats.push_back(it);
    beats_queued++;
  endtask

  task automatic queue_conv(input logic [23:0] value);
    item_t it;
    it.op = OP_CONV_DATA;
    it.spi_in = 8'($urandom_range(0, 255));
    it.conv_value = value;
    host_beats.push_back(it);
    beats_queued++;
  endtask

  task automatic queue_prom_read(input word_idx_t idx);
    queue_spi({CMD_PROM_NIB, idx, 1'($urandom_range(0, 1))});
    queue_spi(8'($urandom_range(0, 255)));
    queue_spi(8'($urandom_range(0, 255)));
  endtask

  task automatic queue_adc_read;
    queue_spi(CMD_ADC_READ);
    repeat (4) queue_spi(8'($urandom_range(0, 255)));
  endtask

  task automatic write_coeff(input cfg_idx_t idx, input coeff_t val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    if (idx < NUM_COEFF) slave_coeff[idx] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained;
    while (host_beats.size() != 0 || in_valid || replies_due.size() != 0) @(posedge clk);
  endtask

  task automatic queue_random_traffic(input int count);
    int start;
    int pick;
    int strays;
    logic temp;
    start = beats_queued;
    while (beats_queued - start < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
        queue_prom_read(3'($urandom_range(0, 7)));
      end else if (pick < 42) begin
        // conversion command, up to two ignored bytes, then the data beat
        temp = 1'($urandom_range(0, 1));
        strays = $urandom_range(0, 2);
        queue_spi({temp ? CMD_D2_NIB : CMD_D1_NIB, 4'($urandom_range(0, 15))});
        repeat (strays) queue_spi(8'($urandom_range(0, 255)));
        queue_conv(24'($urandom_range(0, 24'hFFFFFF)));
      end else if (pick < 62) begin
        queue_adc_read();
      end else if (pick < 72) begin
        queue_spi(CMD_RESET);
        queue_spi(8'($urandom_range(0, 255)));
      end else if (pick < 88) begin
        queue_spi(8'($urandom_range(0, 255)));
      end else begin
        queue_conv(24'($urandom_range(0, 24'hFFFFFF)));
      end
    end
  endtask

  initial begin
    cfg_idx_t spare;
    for (int i = 0; i < NUM_COEFF; i++) slave_coeff[i] = COEFF_RESET[i];
    slave_phase = PH_IDLE;
    slave_word = '0;
    slave_conv = '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset calibration words, every command and odd case
    queue_conv(24'hFFFFFF);                 // data with nothing pending
    queue_spi(8'hFF);                       // unknown command
    queue_adc_read();                       // nothing stored yet
    queue_spi({CMD_D1_NIB, 4'hF});
    queue_spi(8'hFF);                       // ignored while pending
    queue_conv(24'hFFFFFF);
    queue_adc_read();
    queue_spi({CMD_D2_NIB, 4'h0});
    queue_conv(24'h000000);
    queue_spi({CMD_PROM_NIB, PROM_IDX_FIRST, 1'b0});
    queue_conv(24'h5A5A5A);                 // data in mid prom answer
    queue_spi(CMD_ADC_READ);
    queue_spi({CMD_PROM_NIB, 4'h0});        // trailing byte, not a command
    queue_spi({CMD_PROM_NIB, PROM_IDX_LAST, 1'b1});
    queue_spi(8'h00);
    queue_spi(8'hFF);
    queue_spi(CMD_RESET);
    queue_spi(CMD_ADC_READ);

    for (int r = 0; r < RANDOM_ROUNDS; r++) begin
      wait_drained();
      for (int i = 0; i < NUM_COEFF; i++) begin
        if (r == 0) write_coeff(3'(i), 16'h0000);
        else if (r == 1) write_coeff(3'(i), 16'hFFFF);
        else write_coeff(3'(i), 16'($urandom_range(0, 16'hFFFF)));
      end
      // indexes past the last word must leave the words alone
      if (r >= 4) begin
        spare = 3'($urandom_range(NUM_COEFF, 7));
        write_coeff(spare, 16'($urandom_range(0, 16'hFFFF)));
      end
      no_gaps = (r == 3);
      queue_random_traffic(BEATS_PER_ROUND);
    end

    wait_drained();
    no_gaps = 1'b0;
    repeat (8) @(posedge clk);
    if (replies_due.size() != 0) report_mismatch("replies never seen", replies_due.size(), 0);
    if (mismatch_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #200000;
    $display("status: fail");
    $finish;
  end

endmodule
